FILE: hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue unit.
`default_nettype none

package dq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_QUERY      = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [WORD_W-1:0] push_value;
    } t_dq_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic                     popped_valid;
        logic                     overflow;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
    } t_dq_res;

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic look;
        logic done;
    } t_dq_ctl;

endpackage

`default_nettype wire

FILE: hdl/dq_ctrl.sv
// Sequencer for the double-ended queue: accept, execute, look up ends, report.
`default_nettype none

module dq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output dq_pkg::t_dq_ctl     o_ctl,
    output logic                busy
);

    dq_pkg::t_state r_state;
    dq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dq_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC: n_state = dq_pkg::ST_LOOK;
            dq_pkg::ST_LOOK: n_state = dq_pkg::ST_DONE;
            dq_pkg::ST_DONE: n_state = dq_pkg::ST_IDLE;
            default:         n_state = dq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        busy  = 1'b1;
        unique case (r_state)
            dq_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_ctl.load = start;
            end
            dq_pkg::ST_EXEC: o_ctl.exec = 1'b1;
            dq_pkg::ST_LOOK: o_ctl.look = 1'b1;
            dq_pkg::ST_DONE: o_ctl.done = 1'b1;
            default:         busy = 1'b1;
        endcase
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.done |=> !o_ctl.done)
        else $error("result strobe longer than one cycle");

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.done |-> $past(o_ctl.load, 3))
        else $error("result strobe without matching request");

endmodule

`default_nettype wire

FILE: hdl/dq_datapath.sv
// Ring-buffer storage, pointers and result assembly for the double-ended queue.
`default_nettype none

module dq_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dq_pkg::t_dq_ctl i_ctl,
    input  wire dq_pkg::t_dq_req i_req,
    output dq_pkg::t_dq_res      o_result
);

    localparam int SUM_W = dq_pkg::CNT_W + 1;

    logic signed [dq_pkg::WORD_W-1:0] r_mem [dq_pkg::DEPTH];

    logic [2:0]                       r_cmd;
    logic signed [dq_pkg::WORD_W-1:0] r_val;
    logic [dq_pkg::ADDR_W-1:0]        r_head;
    logic [dq_pkg::CNT_W-1:0]         r_count;
    logic signed [dq_pkg::WORD_W-1:0] r_rd_a;
    logic signed [dq_pkg::WORD_W-1:0] r_rd_b;
    logic signed [dq_pkg::WORD_W-1:0] r_popped;
    logic                             r_popped_valid;
    logic                             r_overflow;

    logic [dq_pkg::ADDR_W-1:0]        n_head;
    logic [dq_pkg::CNT_W-1:0]         n_count;

    logic                             empty;
    logic                             full;
    logic [SUM_W-1:0]                 tail_sum;
    logic [SUM_W-1:0]                 after_sum;
    logic [dq_pkg::ADDR_W-1:0]        tail_addr;
    logic [dq_pkg::ADDR_W-1:0]        after_addr;
    logic [dq_pkg::ADDR_W-1:0]        head_dec;
    logic [dq_pkg::ADDR_W-1:0]        head_inc;
    logic [dq_pkg::ADDR_W-1:0]        wr_addr;
    logic                             wr_en;
    logic [dq_pkg::ADDR_W-1:0]        rd_a_addr;
    logic                             is_push;
    logic                             is_pop;

    assign empty = (r_count == '0);
    assign full  = (r_count == dq_pkg::CNT_W'(dq_pkg::DEPTH));

    // Both sums stay below twice the depth, so one conditional subtract wraps them.
    always_comb begin
        tail_sum  = SUM_W'(r_head) + SUM_W'(r_count) - SUM_W'(1);
        after_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (empty) begin
            tail_sum = SUM_W'(r_head);
        end
        if (tail_sum >= SUM_W'(dq_pkg::DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(dq_pkg::DEPTH);
        end
        if (after_sum >= SUM_W'(dq_pkg::DEPTH)) begin
            after_sum = after_sum - SUM_W'(dq_pkg::DEPTH);
        end
        tail_addr  = tail_sum[dq_pkg::ADDR_W-1:0];
        after_addr = after_sum[dq_pkg::ADDR_W-1:0];
        head_dec   = (r_head == '0) ? dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1)
                                    : r_head - dq_pkg::ADDR_W'(1);
        head_inc   = (r_head == dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1)) ? '0
                                    : r_head + dq_pkg::ADDR_W'(1);
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        wr_addr = after_addr;
        wr_en   = 1'b0;
        is_push = 1'b0;
        is_pop  = 1'b0;
        unique case (r_cmd)
            dq_pkg::CMD_PUSH_FRONT: begin
                is_push = 1'b1;
                wr_addr = head_dec;
                if (!full) begin
                    wr_en   = i_ctl.exec;
                    n_head  = head_dec;
                    n_count = r_count + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::CMD_PUSH_BACK: begin
                is_push = 1'b1;
                if (!full) begin
                    wr_en   = i_ctl.exec;
                    n_count = r_count + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                is_pop = 1'b1;
                if (!empty) begin
                    n_head  = head_inc;
                    n_count = r_count - dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                is_pop = 1'b1;
                if (!empty) begin
                    n_count = r_count - dq_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_head = r_head;
            end
        endcase
    end

    // Port A: popped word while executing, front word afterwards. Port B: back word.
    assign rd_a_addr = (i_ctl.exec && r_cmd == dq_pkg::CMD_POP_BACK) ? tail_addr : r_head;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_val;
        end
        r_rd_a <= r_mem[rd_a_addr];
        r_rd_b <= r_mem[tail_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_req.command;
            r_val <= i_req.push_value;
        end
        if (i_ctl.exec) begin
            r_popped_valid <= is_pop && !empty;
            r_overflow     <= is_push && full;
        end
        if (i_ctl.look) begin
            r_popped <= r_rd_a;
        end
    end

    always_comb begin
        o_result.popped_value = r_popped_valid ? r_popped : dq_pkg::NEG_ONE;
        o_result.popped_valid = r_popped_valid;
        o_result.overflow     = r_overflow;
        o_result.entry_count  = r_count;
        o_result.is_empty     = empty;
        o_result.front_value  = empty ? dq_pkg::NEG_ONE : r_rd_a;
        o_result.back_value   = empty ? dq_pkg::NEG_ONE : r_rd_b;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("entry count beyond capacity");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.done |-> !(o_result.popped_valid && o_result.overflow))
        else $error("pop and refused push flagged together");

    a_ptr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.exec |=> ($stable(r_head) && $stable(r_count)))
        else $error("pointers moved outside execute cycle");

endmodule

`default_nettype wire

FILE: hdl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: controller plus datapath.
// Sequence: an accepted request passes execute and end lookup, then its result is strobed.
// Requests: one at a time (accept, execute, end lookup, result); busy holds off the next
//   request until idle again, as the two registered memory reads (popped word, then new ends) come in turn.
// Reset: synchronous active-low; queue empties (head and count cleared), storage untouched.
// Results are shown for exactly one cycle on o_valid; the receiver cannot stall.
`default_nettype none

module double_ended_queue_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire dq_pkg::t_dq_req i_request,
    output logic                 busy,
    output logic                 o_valid,
    output dq_pkg::t_dq_res      o_result
);

    // Command bundle from sequencer to datapath.
    dq_pkg::t_dq_ctl ctl;

    // Sequencer: idle until start, then the execute, lookup and result states in turn.
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    // Datapath: ring buffer, head/count registers, result fields.
    dq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_req    (i_request),
        .o_result (o_result)
    );

    // Result strobe is the sequencer's report cycle.
    assign o_valid = ctl.done;

endmodule

`default_nettype wire

FILE: sim/deque_result_checker.sv
// Scoreboard for the double-ended queue unit: mirrors the queue and checks every result.
`timescale 1ns / 100ps

module deque_result_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_busy,
    input  wire dq_pkg::t_dq_req i_request,
    input  wire logic            i_valid,
    input  wire dq_pkg::t_dq_res i_result,
    output int                   o_fail_count,
    output int                   o_pending
);
    import dq_pkg::*;

    // Mirror of the ring buffer; only held slots are ever read.
    logic signed [WORD_W-1:0] mirror_words [DEPTH];
    int                       mirror_head;
    int                       mirror_held;

    t_dq_res                  expected_results [$];
    t_dq_res                  want;
    int                       misses;
    int                       fail_total = 0;
    int                       pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic apply_command(input t_dq_req req, output t_dq_res res);
        res.popped_value = NEG_ONE;
        res.popped_valid = 1'b0;
        res.overflow     = 1'b0;
        case (req.command)
            CMD_PUSH_FRONT: begin
                if (mirror_held >= DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
                    mirror_words[mirror_head] = req.push_value;
                    mirror_held++;
                end
            end
            CMD_PUSH_BACK: begin
                if (mirror_held >= DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    mirror_words[(mirror_head + mirror_held) % DEPTH] = req.push_value;
                    mirror_held++;
                end
            end
            CMD_POP_FRONT: begin
                if (mirror_held != 0) begin
                    res.popped_value = mirror_words[mirror_head];
                    res.popped_valid = 1'b1;
                    mirror_head = (mirror_head + 1) % DEPTH;
                    mirror_held--;
                end
            end
            CMD_POP_BACK: begin
                if (mirror_held != 0) begin
                    res.popped_value = mirror_words[(mirror_head + mirror_held - 1) % DEPTH];
                    res.popped_valid = 1'b1;
                    mirror_held--;
                end
            end
            default: ;  // query and spare codes leave the queue alone
        endcase
        res.entry_count = CNT_W'(mirror_held);
        res.is_empty    = (mirror_held == 0);
        res.front_value = (mirror_held == 0) ? NEG_ONE : mirror_words[mirror_head];
        res.back_value  = (mirror_held == 0) ? NEG_ONE
                        : mirror_words[(mirror_head + mirror_held - 1) % DEPTH];
    endtask

    function automatic int field_differs(string label, logic [WORD_W-1:0] expected_val,
                                         logic [WORD_W-1:0] actual_val);
        if (actual_val !== expected_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, label, expected_val, actual_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mirror_head = 0;
            mirror_held = 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_result);
                    fail_total++;
                end else begin
                    // oldest expected result sits at index zero
                    want = expected_results[0];
                    expected_results.delete(0);
                    misses = field_differs("popped_value", want.popped_value,
                                           i_result.popped_value)
                           + field_differs("popped_valid", want.popped_valid,
                                           i_result.popped_valid)
                           + field_differs("overflow", want.overflow, i_result.overflow)
                           + field_differs("entry_count", want.entry_count,
                                           i_result.entry_count)
                           + field_differs("is_empty", want.is_empty, i_result.is_empty)
                           + field_differs("front_value", want.front_value,
                                           i_result.front_value)
                           + field_differs("back_value", want.back_value,
                                           i_result.back_value);
                    if (misses != 0) begin
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_command(i_request, want);
                expected_results.insert(expected_results.size(), want);
            end
        end
        pending_total = expected_results.size();
    end

endmodule

FILE: sim/tb_double_ended_queue_unit.sv
// Testbench top for the double-ended queue unit: request stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
    import dq_pkg::*;

    // Watchdog: a clean run stays well within this limit even with every gap at its longest.
    localparam int CYCLE_LIMIT  = 200000;
    // Result is strobed after execute and end lookup; give it a little more before the verdict.
    localparam int DRAIN_CYCLES = 8;

    // Codes above query are unused and must act as a query.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    logic    o_valid;
    t_dq_req request;
    t_dq_res result;

    int      fail_count;
    int      pending_count;
    int      cycle_count = 0;
    int      queue_fill;     // words held, tracked only to steer the stimulus
    bit      calm;           // no sender gaps while set

    double_ended_queue_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (request),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_result  (result)
    );

    deque_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_request    (request),
        .i_valid      (o_valid),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("double_ended_queue_unit test failed");
            $finish;
        end
    end

    // Extremes and sign patterns show up often; the rest is any 32-bit word.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return NEG_ONE;
            3:       return '0;
            4:       return WORD_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    // Weighted draw: push_pct pushes, pop_pct pops, the rest query or spare codes.
    function automatic logic [2:0] pick_command(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct) begin
            return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else if (roll < push_pct + pop_pct) begin
            return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        return 3'($urandom_range(CMD_QUERY, CMD_SPARE_LAST));
    endfunction

    // Called just after a falling edge with start not yet touched in this step.
    // Returns just after the falling edge that follows the accepting edge.
    task automatic send_request(input logic [2:0] cmd, input logic signed [WORD_W-1:0] value);
        // random sender gap, long enough to straddle the block's idle phase too
        if (!calm && $urandom_range(99) < 28) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start   <= 1'b1;
        request <= '{command: cmd, push_value: value};
        do begin
            @(posedge i_clk);
        end while (busy);
        @(negedge i_clk);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: if (queue_fill < DEPTH) queue_fill++;
            CMD_POP_FRONT, CMD_POP_BACK:   if (queue_fill > 0) queue_fill--;
            default: ;
        endcase
    endtask

    // Hold requests off until every outstanding result has come back.
    task automatic wait_until_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int k;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        request    = '0;
        calm       = 1'b0;
        queue_fill = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed: empty queue, extremes, spare codes, single-entry ends ---
        send_request(CMD_QUERY, WORD_MAX);
        send_request(CMD_POP_FRONT, WORD_MIN);      // pop from empty
        send_request(CMD_POP_BACK, NEG_ONE);        // pop from empty
        send_request(CMD_PUSH_FRONT, WORD_MAX);     // head wraps below slot zero
        send_request(CMD_PUSH_BACK, WORD_MIN);
        send_request(CMD_PUSH_FRONT, NEG_ONE);
        send_request(CMD_PUSH_BACK, '0);
        for (k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++) begin
            send_request(3'(k), pick_word());
        end
        send_request(CMD_QUERY, '0);
        send_request(CMD_POP_BACK, pick_word());
        send_request(CMD_POP_FRONT, pick_word());
        send_request(CMD_POP_FRONT, pick_word());
        send_request(CMD_POP_BACK, pick_word());    // back to empty
        send_request(CMD_POP_BACK, pick_word());    // pop from empty again
        send_request(CMD_PUSH_BACK, WORD_MAX);      // one entry: front equals back
        send_request(CMD_POP_FRONT, pick_word());
        send_request(CMD_PUSH_FRONT, WORD_MIN);
        send_request(CMD_POP_BACK, pick_word());

        // sender pause: let the pipeline empty completely once
        wait_until_drained();

        // --- shallow queue: frequent empty pops, every code ---
        repeat (200) send_request(pick_command(40, 40), pick_word());

        // --- fill to capacity, with a long gap-free stretch in the middle ---
        k = 0;
        while (queue_fill < DEPTH) begin
            calm = (k >= 300 && k < 700);
            send_request(pick_command(96, 2), pick_word());
            k++;
        end
        calm = 1'b0;

        // --- hover at full: refused pushes at both ends ---
        repeat (40) send_request(pick_command(60, 25), pick_word());
        wait_until_drained();

        // --- pop-heavy drain from near full ---
        repeat (120) send_request(pick_command(15, 70), pick_word());

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("double_ended_queue_unit test passed");
        end else begin
            $display("double_ended_queue_unit test failed");
        end
        $finish;
    end

endmodule
